@@ hw/rtl/eas_pkg.sv @@
// Package: shared types, constants and helpers for the encoder angle/speed filter
`timescale 1ns / 1ps
`default_nettype none
package eas_pkg;
	localparam int WINDOW_SAMPLES_DEF = 3;
	localparam logic [16:0] GAIN_RST = 17'd19661;
	localparam logic [15:0] CPT_RST = 16'd1320;
	localparam logic [16:0] GAIN_ONE = 17'd65536;
	localparam logic [16:0] DEG_Q8 = 17'd92160;
	localparam logic [26:0] DEG_MS_Q8 = 27'd92160000;

	typedef enum logic [1:0] {
		REG_GAIN = 2'd0,
		REG_CPT = 2'd1,
		REG_INV_L = 2'd2,
		REG_INV_R = 2'd3
	} reg_idx_t;

	// back end sequencer states
	typedef enum logic [2:0] {B_IDLE, B_MUL, B_DIV, B_WAIT, B_POST, B_DONE} bst_t;

	typedef struct packed {
		logic [16:0] gain;
		logic [15:0] cpt;
		logic inv_l;
		logic inv_r;
	} cfg_t;

	// one classified item from the front to the back
	typedef struct packed {
		logic [31:0] total_l;
		logic [31:0] total_r;
		logic [19:0] sum_l;
		logic [19:0] sum_r;
		logic [31:0] elapsed;
		logic close;
	} job_t;

	typedef struct packed {
		logic [31:0] angle_l;
		logic [31:0] angle_r;
		logic [31:0] speed_l;
		logic [31:0] speed_r;
		logic valid;
	} res_t;

	// saturate a 64-bit signed value to 32 bits
	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

@@ hw/rtl/eas_front.sv @@
// Front end: wrap-safe deltas, totals, window bookkeeping
`timescale 1ns / 1ps
`default_nettype none
module eas_front #(
	parameter int WINDOW_SAMPLES = eas_pkg::WINDOW_SAMPLES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_take,
	input wire logic [15:0] count_left,
	input wire logic [15:0] count_right,
	input wire logic [31:0] now_ms,
	output eas_pkg::job_t job
);
	import eas_pkg::*;
	localparam int PW = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;

	logic [15:0] prev_l_q, prev_r_q;
	logic [31:0] tot_l_q, tot_r_q, start_q, prev_start_q;
	logic [19:0] sum_l_q, sum_r_q;
	logic [PW-1:0] pos_q;
	logic signed [15:0] dl, dr;
	logic [19:0] nsum_l, nsum_r;
	logic [31:0] start_n;
	logic close;

	always_comb begin
		dl = $signed(count_left - prev_l_q);
		dr = $signed(count_right - prev_r_q);
		nsum_l = sum_l_q + {{4{dl[15]}}, dl};
		nsum_r = sum_r_q + {{4{dr[15]}}, dr};
		start_n = (pos_q == '0) ? now_ms : start_q;
		close = (32'(pos_q) + 32'd1 >= 32'(WINDOW_SAMPLES));
		job.total_l = tot_l_q + {{16{dl[15]}}, dl};
		job.total_r = tot_r_q + {{16{dr[15]}}, dr};
		job.sum_l = nsum_l;
		job.sum_r = nsum_r;
		job.elapsed = start_n - prev_start_q;
		job.close = close;
	end

	// advance state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0; prev_r_q <= '0; tot_l_q <= '0; tot_r_q <= '0;
			sum_l_q <= '0; sum_r_q <= '0; pos_q <= '0;
			start_q <= '0; prev_start_q <= '0;
		end else if (in_take) begin
			prev_l_q <= count_left;
			prev_r_q <= count_right;
			tot_l_q <= job.total_l;
			tot_r_q <= job.total_r;
			start_q <= start_n;
			if (close) begin
				prev_start_q <= start_n;
				sum_l_q <= '0; sum_r_q <= '0; pos_q <= '0;
			end else begin
				sum_l_q <= nsum_l; sum_r_q <= nsum_r;
				pos_q <= pos_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/eas_divu.sv @@
// Iterative unsigned restoring divider with rounding to nearest
`timescale 1ns / 1ps
`default_nettype none
module eas_divu (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [63:0] num,
	input wire logic [47:0] den,
	output logic done,
	output logic [63:0] quo
);
	import eas_pkg::*;
	logic [63:0] n_q, q_q;
	logic [48:0] r_q;
	logic [47:0] d_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [48:0] r_sh;
	logic ge;

	always_comb begin
		r_sh = {r_q[47:0], n_q[63]};
		ge = r_sh >= {1'b0, d_q};
	end

	// shift one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; done <= 1'b0; cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1; cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin busy_q <= 1'b0; done <= 1'b1; end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num + {17'd0, den[47:1]}; d_q <= den; r_q <= '0; q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[62:0], 1'b0};
			r_q <= ge ? r_sh - {1'b0, d_q} : r_sh;
			q_q <= {q_q[62:0], ge};
		end
	end
	assign quo = q_q;
endmodule
`default_nettype wire

@@ hw/rtl/eas_back.sv @@
// Back end: angle scaling, speed division and low-pass filter sequencer
`timescale 1ns / 1ps
`default_nettype none
module eas_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire eas_pkg::cfg_t cfg,
	input wire logic job_vld,
	input wire eas_pkg::job_t job,
	output logic job_take,
	input wire logic res_free,
	output logic res_load,
	output eas_pkg::res_t res
);
	import eas_pkg::*;
	bst_t st_q, st_n;
	logic [1:0] op_q;
	job_t job_q;
	logic signed [31:0] filt_l_q, filt_r_q;
	logic [31:0] ang_l_q, ang_r_q, raw_l_q, raw_r_q;
	logic neg_q;
	logic [63:0] mag_q;
	logic [47:0] den_q;
	logic dstart, ddone;
	logic [63:0] quo;
	logic [15:0] cpt;
	logic [16:0] g;

	assign cpt = (cfg.cpt == '0) ? 16'd1 : cfg.cpt;
	assign g = (cfg.gain > GAIN_ONE) ? GAIN_ONE : cfg.gain;

	eas_divu u_div (.clk, .arst_n, .start(dstart), .num(mag_q), .den(den_q),
		.done(ddone), .quo);

	// operand of current op: 0 angle L, 1 angle R, 2 speed L, 3 speed R
	logic signed [63:0] prod;
	logic inv;
	always_comb begin
		inv = op_q[0] ? cfg.inv_r : cfg.inv_l;
		case (op_q)
			2'd0: prod = $signed(job_q.total_l) * $signed({15'd0, DEG_Q8});
			2'd1: prod = $signed(job_q.total_r) * $signed({15'd0, DEG_Q8});
			2'd2: prod = $signed(job_q.sum_l) * $signed({5'd0, DEG_MS_Q8});
			default: prod = $signed(job_q.sum_r) * $signed({5'd0, DEG_MS_Q8});
		endcase
	end

	logic signed [64:0] sq, r65;
	logic [31:0] rv;
	always_comb begin
		sq = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		if (op_q[1] && job_q.elapsed == '0)
			sq = (mag_q == '0) ? 65'sd0 : (neg_q ? -65'sd1099511627776 : 65'sd1099511627776);
		r65 = inv ? -sq : sq;
		rv = (r65 > 65'sd2147483647) ? 32'h7fffffff :
			(r65 < -65'sd2147483648) ? 32'h80000000 : r65[31:0];
	end

	// low-pass on registered raw speeds
	function automatic logic [31:0] lp(input logic [31:0] raw, input logic [31:0] prv,
		input logic [16:0] gg);
		logic signed [63:0] acc;
		logic [63:0] m;
		logic signed [63:0] q;
		acc = $signed({{32{raw[31]}}, raw}) * $signed({47'd0, gg})
			+ $signed({{32{prv[31]}}, prv}) * $signed({47'd0, GAIN_ONE - gg});
		m = acc[63] ? 64'(-acc) : 64'(acc);
		m = (m + 64'd32768) >> 16;
		q = acc[63] ? -$signed(m) : $signed(m);
		return sat32(q);
	endfunction

	logic fin;
	always_comb begin
		st_n = st_q; job_take = 1'b0; dstart = 1'b0; res_load = 1'b0;
		fin = (op_q == 2'd3) || (op_q == 2'd1 && !job_q.close);
		case (st_q)
			B_IDLE: if (job_vld) begin job_take = 1'b1; st_n = B_MUL; end
			B_MUL: st_n = B_DIV;
			B_DIV: begin dstart = 1'b1; st_n = B_WAIT; end
			B_WAIT: if (ddone) st_n = B_POST;
			B_POST: st_n = fin ? B_DONE : B_MUL;
			B_DONE: if (res_free) begin res_load = 1'b1; st_n = B_IDLE; end
			default: st_n = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE; op_q <= '0; filt_l_q <= '0; filt_r_q <= '0;
		end else begin
			st_q <= st_n;
			if (job_take) op_q <= '0;
			if (st_q == B_POST && !fin) op_q <= op_q + 1'b1;
			if (st_q == B_DONE && res_free && job_q.close) begin
				filt_l_q <= lp(raw_l_q, filt_l_q, g);
				filt_r_q <= lp(raw_r_q, filt_r_q, g);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) job_q <= job;
		if (st_q == B_MUL) begin
			neg_q <= prod[63];
			mag_q <= prod[63] ? 64'(-prod) : 64'(prod);
			den_q <= op_q[1] ? 48'(cpt) * 48'(job_q.elapsed) : 48'(cpt);
		end
		if (st_q == B_POST) begin
			case (op_q)
				2'd0: ang_l_q <= rv;
				2'd1: ang_r_q <= rv;
				2'd2: raw_l_q <= rv;
				default: raw_r_q <= rv;
			endcase
		end
	end

	always_comb begin
		res.angle_l = ang_l_q;
		res.angle_r = ang_r_q;
		res.speed_l = job_q.close ? lp(raw_l_q, filt_l_q, g) : filt_l_q;
		res.speed_r = job_q.close ? lp(raw_r_q, filt_r_q, g) : filt_r_q;
		res.valid = job_q.close;
	end
endmodule
`default_nettype wire

@@ hw/rtl/encoder_angle_speed_filter.sv @@
// Top level: encoder angle and filtered speed estimator for two wheels
// Usage:
//  Input queue side: push with count_left/right and now_ms while full is low.
//  Result queue side: while empty is low the oldest result is on the angle,
//  speed and speed_valid ports; pop takes it.
//  Configuration: cfg_we with cfg_index (0 gain, 1 counts per turn, 2 invert
//  left, 3 invert right) and cfg_wdata, only while idle.
//  Work per item: an item without window close takes two 64-step divider
//  runs (the angles); a window-closing item takes four (angles and speeds).
//  The shared 64-bit serial divider paces the back end.
//  The front takes each accepted push into a two-entry queue; the back
//  drains it at the divider's pace, and a single output register holds the
//  finished result so the back works on the next item meanwhile.
//  Reset clears control state and filters and loads default configuration.
//  A stalled receiver holds the output register; the back then waits and
//  the job queue fills, raising full.
`timescale 1ns / 1ps
`default_nettype none
module encoder_angle_speed_filter #(
	parameter int WINDOW_SAMPLES = eas_pkg::WINDOW_SAMPLES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [15:0] count_left,
	input wire logic [15:0] count_right,
	input wire logic [31:0] now_ms,
	output logic empty,
	input wire logic pop,
	output logic signed [31:0] angle_left,
	output logic signed [31:0] angle_right,
	output logic signed [31:0] speed_left,
	output logic signed [31:0] speed_right,
	output logic speed_valid,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [16:0] cfg_wdata
);
	import eas_pkg::*;
	cfg_t cfg_q;
	job_t fjob, qjob;
	job_t jq_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic take, jtake, rload, ovld_q;
	res_t res, out_q;

	// store configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain <= GAIN_RST; cfg_q.cpt <= CPT_RST;
			cfg_q.inv_l <= 1'b0; cfg_q.inv_r <= 1'b1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_GAIN: cfg_q.gain <= cfg_wdata;
				REG_CPT: cfg_q.cpt <= cfg_wdata[15:0];
				REG_INV_L: cfg_q.inv_l <= cfg_wdata[0];
				REG_INV_R: cfg_q.inv_r <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign full = (cnt_q == 2'd2);
	assign take = push && !full;

	eas_front #(.WINDOW_SAMPLES(WINDOW_SAMPLES)) u_front (.clk, .arst_n,
		.in_take(take), .count_left, .count_right, .now_ms, .job(fjob));

	// two-entry job queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0;
		end else begin
			if (take) wr_q <= ~wr_q;
			if (jtake) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, take} - {1'b0, jtake};
		end
	end
	always_ff @(posedge clk) begin
		if (take) jq_q[wr_q] <= fjob;
	end
	assign qjob = jq_q[rd_q];

	eas_back u_back (.clk, .arst_n, .cfg(cfg_q), .job_vld(cnt_q != '0), .job(qjob),
		.job_take(jtake), .res_free(!ovld_q || pop), .res_load(rload), .res);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovld_q <= 1'b0;
		else if (rload) ovld_q <= 1'b1;
		else if (pop) ovld_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (rload) out_q <= res;
	end

	assign empty = !ovld_q;
	assign angle_left = out_q.angle_l;
	assign angle_right = out_q.angle_r;
	assign speed_left = out_q.speed_l;
	assign speed_right = out_q.speed_r;
	assign speed_valid = out_q.valid;
endmodule
`default_nettype wire

@@ hw/rtl/eas_checker.sv @@
// Checker: port-level assertions for the encoder angle/speed filter
`timescale 1ns / 1ps
`default_nettype none
module eas_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic full,
	input wire logic empty,
	input wire logic pop,
	input wire logic speed_valid,
	input wire logic signed [31:0] speed_left
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty) else $error("result dropped while stalled");
	a_spd: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(speed_left)) else $error("speed changed");
	a_vld: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(speed_valid)) else $error("speed_valid changed");
	a_rst: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("reset state");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({push, full, empty})) else $error("unknown handshake");
endmodule
bind encoder_angle_speed_filter eas_checker u_chk (.clk, .arst_n, .push, .full,
	.empty, .pop, .speed_valid, .speed_left);
`default_nettype wire
